>>> hdl/sad_pkg.sv
`default_nettype none
package sad_pkg;

    localparam int STICK_W = 12;
    localparam int TIME_W  = 32;
    localparam int DLY_W   = 16;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING = 2'd2;

    localparam logic [DLY_W-1:0] DEBOUNCE_RESET = 16'd1000;

    // arm gesture: throttle low, yaw full left
    localparam logic [STICK_W-1:0] ARM_THR_LT  = 12'd1065;
    localparam logic [STICK_W-1:0] ARM_YAW_LT  = 12'd1050;
    // run gesture: throttle below 1550, yaw above 1450
    localparam logic [STICK_W-1:0] RUN_THR_LT  = 12'd1550;
    localparam logic [STICK_W-1:0] RUN_YAW_GT  = 12'd1450;
    // disarm gesture: throttle low, yaw full right
    localparam logic [STICK_W-1:0] STOP_THR_LE = 12'd1064;
    localparam logic [STICK_W-1:0] STOP_YAW_GT = 12'd1976;

    typedef struct packed {
        logic [STICK_W-1:0] throttle_us;
        logic [STICK_W-1:0] yaw_us;
        logic [TIME_W-1:0]  now_ms;
    } sample_t;

endpackage
`default_nettype wire

>>> hdl/sad_if.sv
`default_nettype none
interface sad_sample_if import sad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STICK_W-1:0] throttle_us;
    logic [STICK_W-1:0] yaw_us;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output throttle_us, output yaw_us, output now_ms,
                    input ready);
    modport sink   (input valid, input throttle_us, input yaw_us, input now_ms,
                    output ready);
endinterface

interface sad_result_if import sad_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] arm_state;
    logic              resync_attitude;

    modport source (output valid, output arm_state, output resync_attitude, input ready);
    modport sink   (input valid, input arm_state, input resync_attitude, output ready);
endinterface

interface sad_cfg_if import sad_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DLY_W-1:0] debounce_ms;

    modport source (output valid, output debounce_ms, input ready);
    modport sink   (input valid, input debounce_ms, output ready);
endinterface
`default_nettype wire

>>> hdl/stick_arm_disarm_fsm.sv
// Path: an accepted sample request is held in the input register and moves into the result
//   register when that register is empty or its result is being taken.
// Throughput: one sample per cycle while the result side keeps taking results; the arm state,
//   pending flag and gesture time are updated in a single pass between the input register and the result register.
// Reset (rst_n, async, active low): state off, no gesture pending, gesture time 0,
//   debounce delay 1000 ms, both pipeline registers empty.
`default_nettype none
module stick_arm_disarm_fsm import sad_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sad_sample_if.sink    sample,
    sad_cfg_if.sink       cfg,
    sad_result_if.source  result
);

    // Hold one sample request; it moves on as soon as the result register frees up.
    sample_t item;
    logic    item_valid;
    logic    item_take;

    sad_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    // Apply the three stick gestures in order (arm, run, disarm), each seeing the
    // mode left by the one before. One shared debounce timer serves all gestures:
    // a gesture must persist strictly longer than the debounce delay, measured
    // with wrapping 32-bit time. Drop the pending flag when no gesture holds.
    // The result register carries the new mode and a resync pulse on entering
    // running; it accepts the next result while the current one is being taken.
    sad_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .cfg        (cfg),
        .result     (result)
    );

endmodule
`default_nettype wire

>>> hdl/sad_in_reg.sv
`default_nettype none
module sad_in_reg import sad_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sad_sample_if.sink   sample,
    output sample_t      item,
    output logic         item_valid,
    input  wire logic    item_take
);

    sample_t item_reg;
    logic    valid_reg;

    // take a new request when empty or when the held one leaves this cycle
    assign sample.ready = !valid_reg || item_take;
    assign item         = item_reg;
    assign item_valid   = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.valid && sample.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            item_reg.throttle_us <= sample.throttle_us;
            item_reg.yaw_us      <= sample.yaw_us;
            item_reg.now_ms      <= sample.now_ms;
        end
    end

endmodule
`default_nettype wire

>>> hdl/sad_core.sv
`default_nettype none
module sad_core import sad_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire sample_t  item,
    input  wire logic     item_valid,
    output logic          item_take,
    sad_cfg_if.sink       cfg,
    sad_result_if.source  result
);

    logic [DLY_W-1:0]  debounce_reg;
    logic [MODE_W-1:0] mode_reg;
    logic              pend_reg;
    logic [TIME_W-1:0] start_reg;
    logic              res_valid_reg;
    logic [MODE_W-1:0] res_state_reg;
    logic              res_resync_reg;

    logic [MODE_W-1:0] mode_next;
    logic              pend_next;
    logic [TIME_W-1:0] start_next;
    logic              resync_next;

    logic              advance;
    logic              elapsed;
    logic              fresh;
    logic              arm_hit;
    logic              run_thr;
    logic              stop_thr;
    logic              run_hit;
    logic              stop_hit;
    logic [TIME_W-1:0] age;

    assign advance   = item_valid && (!res_valid_reg || result.ready);
    assign item_take = advance;
    assign cfg.ready = 1'b1;

    assign age     = item.now_ms - start_reg;
    assign elapsed = age > {{(TIME_W-DLY_W){1'b0}}, debounce_reg};

    assign arm_hit  = (item.throttle_us < ARM_THR_LT) && (item.yaw_us < ARM_YAW_LT);
    assign run_thr  = (item.throttle_us < RUN_THR_LT) && (item.yaw_us > RUN_YAW_GT);
    assign stop_thr = (item.throttle_us <= STOP_THR_LE) && (item.yaw_us > STOP_YAW_GT);

    // rules in order; a timer started this pass is marked fresh, so it cannot expire in the same pass
    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        start_next  = start_reg;
        resync_next = 1'b0;
        fresh       = 1'b0;

        if (arm_hit)
        begin
            if (!pend_next)
            begin
                pend_next  = 1'b1;
                start_next = item.now_ms;
                fresh      = 1'b1;
            end
            else if (elapsed && mode_next == MODE_OFF)
            begin
                mode_next = MODE_START;
                pend_next = 1'b0;
            end
        end

        if (run_thr && mode_next == MODE_START)
        begin
            if (!pend_next)
            begin
                pend_next  = 1'b1;
                start_next = item.now_ms;
                fresh      = 1'b1;
            end
            else if (elapsed && !fresh)
            begin
                mode_next   = MODE_RUNNING;
                pend_next   = 1'b0;
                resync_next = 1'b1;
            end
        end

        if (stop_thr && mode_next == MODE_RUNNING)
        begin
            if (!pend_next)
            begin
                pend_next  = 1'b1;
                start_next = item.now_ms;
                fresh      = 1'b1;
            end
            else if (elapsed && !fresh)
            begin
                mode_next = MODE_OFF;
                pend_next = 1'b0;
            end
        end

        run_hit  = run_thr && (mode_next == MODE_START);
        stop_hit = stop_thr && (mode_next == MODE_RUNNING);
        if (!arm_hit && !run_hit && !stop_hit)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg  <= DEBOUNCE_RESET;
            mode_reg      <= MODE_OFF;
            pend_reg      <= 1'b0;
            start_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                debounce_reg <= cfg.debounce_ms;
            end
            if (advance)
            begin
                mode_reg      <= mode_next;
                pend_reg      <= pend_next;
                start_reg     <= start_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_state_reg  <= mode_next;
            res_resync_reg <= resync_next;
        end
    end

    assign result.valid           = res_valid_reg;
    assign result.arm_state       = res_state_reg;
    assign result.resync_attitude = res_resync_reg;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import sad_pkg::*;

    // Bound the run well beyond the slowest legal pass.
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int          ITEMS_PER_PHASE = 160;
    localparam int          PRESSURE_CYCLES = 300;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          TAIL_CYCLES     = 8;
    localparam int          MAX_PRINTED     = 100;

    typedef struct packed {
        logic [MODE_W-1:0] arm_state;
        logic              resync_attitude;
    } arm_result_t;

    // One directed request; typed rows carry their own expected result.
    typedef struct packed {
        logic [STICK_W-1:0] thr;
        logic [STICK_W-1:0] yaw;
        logic [TIME_W-1:0]  now;
        bit                 typed;
        logic [MODE_W-1:0]  st;
        logic               rs;
    } gesture_row_t;

    typedef enum int {STK_ARM, STK_RUN, STK_STOP, STK_NOISE, STK_EDGE} stick_kind_t;

    localparam int N_ROWS = 22;
    localparam gesture_row_t GESTURE_ROWS [N_ROWS] = '{
        // idle sticks, all bits high
        '{12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1, MODE_OFF,     1'b0},
        // arm gesture: start the timer, then hit the delay exactly, then pass it
        '{12'd0,    12'd0,    32'd100,       1'b1, MODE_OFF,     1'b0},
        '{12'd1064, 12'd1049, 32'd1100,      1'b1, MODE_OFF,     1'b0},
        '{12'd1064, 12'd1049, 32'd1101,      1'b1, MODE_START,   1'b0},
        // throttle at the arm limit: no gesture, timer drops
        '{12'd1065, 12'd1049, 32'd1200,      1'b0, MODE_OFF,     1'b0},
        '{12'd1549, 12'd1451, 32'd5000,      1'b0, MODE_OFF,     1'b0},
        // arm gesture while in start: holds the timer, changes nothing
        '{12'd0,    12'd0,    32'd7000,      1'b0, MODE_OFF,     1'b0},
        '{12'd1549, 12'd4095, 32'd7001,      1'b1, MODE_RUNNING, 1'b1},
        '{12'd1550, 12'd4095, 32'd7002,      1'b0, MODE_OFF,     1'b0},
        // arm gesture in running starts the timer, disarm takes it over
        '{12'd0,    12'd0,    32'd8000,      1'b0, MODE_OFF,     1'b0},
        '{12'd1064, 12'd1977, 32'd9001,      1'b0, MODE_OFF,     1'b0},
        '{12'd1064, 12'd1976, 32'd9002,      1'b0, MODE_OFF,     1'b0},
        // elapsed time across the 32-bit wrap
        '{12'd0,    12'd0,    32'hFFFF_FF00, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd0,    32'h0000_0300, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd1450, 32'h0000_0400, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd1451, 32'h0000_1000, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd1451, 32'h0000_13E8, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd1451, 32'h0000_13E9, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd4095, 32'h0000_2000, 1'b0, MODE_OFF,     1'b0},
        '{12'd4095, 12'd0,    32'h0000_2001, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd4095, 32'h0000_2002, 1'b0, MODE_OFF,     1'b0},
        '{12'd0,    12'd4095, 32'h0000_23EB, 1'b0, MODE_OFF,     1'b0}
    };

    localparam logic [STICK_W-1:0] THR_EDGES [8] = '{
        ARM_THR_LT - 12'd1, ARM_THR_LT, STOP_THR_LE, RUN_THR_LT - 12'd1,
        RUN_THR_LT, RUN_THR_LT + 12'd1, 12'd0, 12'd4095
    };
    localparam logic [STICK_W-1:0] YAW_EDGES [8] = '{
        ARM_YAW_LT - 12'd1, ARM_YAW_LT, RUN_YAW_GT, RUN_YAW_GT + 12'd1,
        STOP_YAW_GT, STOP_YAW_GT + 12'd1, 12'd0, 12'd4095
    };

    logic clk = 1'b0;
    logic rst_n;

    sad_sample_if sample_ch ();
    sad_cfg_if    cfg_ch ();
    sad_result_if result_ch ();

    stick_arm_disarm_fsm u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Arm state predictor: its own copy of mode, debounce flag, gesture time
    // and the delay register.
    logic [MODE_W-1:0] fsm_mode;
    logic              gesture_pending;
    logic [TIME_W-1:0] gesture_t0;
    logic [DLY_W-1:0]  debounce_val;

    arm_result_t expected_q [$];

    int          src_idle;
    int          snk_stall;
    int          hold_cycles;
    int unsigned mismatch_cnt;
    int unsigned cycle_cnt;

    function automatic bit arm_gesture(logic [STICK_W-1:0] thr, logic [STICK_W-1:0] yaw);
        return thr < ARM_THR_LT && yaw < ARM_YAW_LT;
    endfunction

    function automatic bit run_gesture(logic [STICK_W-1:0] thr, logic [STICK_W-1:0] yaw);
        return fsm_mode == MODE_START && thr < RUN_THR_LT && yaw > RUN_YAW_GT;
    endfunction

    function automatic bit stop_gesture(logic [STICK_W-1:0] thr, logic [STICK_W-1:0] yaw);
        return fsm_mode == MODE_RUNNING && thr <= STOP_THR_LE && yaw > STOP_YAW_GT;
    endfunction

    // Start the shared timer if idle; otherwise report whether the gesture
    // has outlasted the delay.
    function automatic bit gesture_held(logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        if (!gesture_pending)
        begin
            gesture_pending = 1'b1;
            gesture_t0      = now;
            return 1'b0;
        end
        elapsed = now - gesture_t0;
        return elapsed > TIME_W'(debounce_val);
    endfunction

    // Apply the three gesture rules in order; each sees the mode left by the one above.
    function automatic arm_result_t step_arm_fsm(logic [STICK_W-1:0] thr,
                                                 logic [STICK_W-1:0] yaw,
                                                 logic [TIME_W-1:0]  now);
        arm_result_t res;
        logic        resync;
        resync = 1'b0;
        if (arm_gesture(thr, yaw))
        begin
            if (gesture_held(now) && fsm_mode == MODE_OFF)
            begin
                fsm_mode        = MODE_START;
                gesture_pending = 1'b0;
            end
        end
        if (run_gesture(thr, yaw))
        begin
            if (gesture_held(now))
            begin
                fsm_mode        = MODE_RUNNING;
                gesture_pending = 1'b0;
                resync          = 1'b1;
            end
        end
        if (stop_gesture(thr, yaw))
        begin
            if (gesture_held(now))
            begin
                fsm_mode        = MODE_OFF;
                gesture_pending = 1'b0;
            end
        end
        // no gesture left standing under the updated mode: drop the timer
        if (!arm_gesture(thr, yaw) && !run_gesture(thr, yaw) && !stop_gesture(thr, yaw))
            gesture_pending = 1'b0;
        res.arm_state       = fsm_mode;
        res.resync_attitude = resync;
        return res;
    endfunction

    // Count every mismatch; cap the printout so a dead block cannot flood the log.
    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTED)
            $display("mismatch @%0t: %s", $realtime, what);
    endtask

    // Offer one sample request, hold it until accepted, then queue its expected result.
    task automatic send_sample(input logic [STICK_W-1:0] thr, input logic [STICK_W-1:0] yaw,
                               input logic [TIME_W-1:0] now, input bit typed,
                               input arm_result_t typed_res);
        arm_result_t pred;
        while ($urandom_range(99) < src_idle)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.throttle_us <= thr;
        sample_ch.yaw_us      <= yaw;
        sample_ch.now_ms      <= now;
        @(posedge clk);
        while (sample_ch.ready !== 1'b1)
            @(posedge clk);
        pred = step_arm_fsm(thr, yaw, now);
        expected_q.push_back(typed ? typed_res : pred);
    endtask

    // Drop valid and let the pipeline empty before touching the register.
    task automatic drain_requests();
        sample_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [DLY_W-1:0] dly);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.debounce_ms <= dly;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        debounce_val = dly;
    endtask

    // One random phase: new delay, new idling mix, mostly well-formed gestures.
    task automatic run_phase(input logic [DLY_W-1:0] dly, input int src, input int snk,
                             input int hold);
        stick_kind_t        kind;
        int                 kind_left;
        int                 pick;
        logic [STICK_W-1:0] thr;
        logic [STICK_W-1:0] yaw;
        logic [TIME_W-1:0]  t;
        drain_requests();
        write_debounce(dly);
        src_idle    = src;
        snk_stall   = snk;
        hold_cycles = hold;
        kind        = STK_NOISE;
        kind_left   = 0;
        t           = $urandom;
        repeat (ITEMS_PER_PHASE)
        begin
            // hold one gesture for a few samples; favor the one the mode can take
            if (kind_left == 0)
            begin
                kind_left = $urandom_range(8, 1);
                if ($urandom_range(99) < 60)
                    kind = fsm_mode == MODE_OFF ? STK_ARM :
                           fsm_mode == MODE_START ? STK_RUN : STK_STOP;
                else
                    kind = stick_kind_t'($urandom_range(4));
            end
            kind_left--;
            case (kind)
                STK_ARM:
                begin
                    thr = STICK_W'($urandom_range(ARM_THR_LT - 1));
                    yaw = STICK_W'($urandom_range(ARM_YAW_LT - 1));
                end
                STK_RUN:
                begin
                    thr = STICK_W'($urandom_range(RUN_THR_LT - 1));
                    yaw = STICK_W'($urandom_range(4095, RUN_YAW_GT + 1));
                end
                STK_STOP:
                begin
                    thr = STICK_W'($urandom_range(STOP_THR_LE));
                    yaw = STICK_W'($urandom_range(4095, STOP_YAW_GT + 1));
                end
                STK_EDGE:
                begin
                    thr = THR_EDGES[$urandom_range(7)];
                    yaw = YAW_EDGES[$urandom_range(7)];
                end
                default:
                begin
                    thr = STICK_W'($urandom_range(4095));
                    yaw = STICK_W'($urandom_range(4095));
                end
            endcase
            // advance time: land on the delay boundary, creep, stride, or jump anywhere
            pick = $urandom_range(99);
            if (gesture_pending && pick < 20)
                t = gesture_t0 + TIME_W'(debounce_val) + $urandom_range(1);
            else if (pick < 25)
                t = $urandom;
            else if (pick < 55)
                t = t + $urandom_range(2);
            else
                t = t + $urandom_range(2 * debounce_val + 2);
            send_sample(thr, yaw, t, 1'b0, '0);
        end
    endtask

    // Result side: check each accepted result against the oldest expectation,
    // then pick the next ready. A pending hold-off forces ready low first.
    initial
    begin : result_sink
        arm_result_t exp_res;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result with nothing expected: state %0d resync %0b",
                                              result_ch.arm_state, result_ch.resync_attitude));
                else
                begin
                    exp_res = expected_q.pop_front();
                    if (result_ch.arm_state !== exp_res.arm_state)
                        report_mismatch($sformatf("arm_state got %0d want %0d",
                                                  result_ch.arm_state, exp_res.arm_state));
                    if (result_ch.resync_attitude !== exp_res.resync_attitude)
                        report_mismatch($sformatf("resync_attitude got %0b want %0b",
                                                  result_ch.resync_attitude,
                                                  exp_res.resync_attitude));
                end
            end
            if (hold_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin : main_seq
        gesture_row_t row;
        // drive every input known from time zero
        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.throttle_us = '0;
        sample_ch.yaw_us      = '0;
        sample_ch.now_ms      = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.debounce_ms    = '0;
        cycle_cnt             = 0;
        mismatch_cnt          = 0;
        src_idle              = 0;
        snk_stall             = 0;
        hold_cycles           = 0;
        fsm_mode              = MODE_OFF;
        gesture_pending       = 1'b0;
        gesture_t0            = '0;
        debounce_val          = DEBOUNCE_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset delay: boundaries, every rule, shared timer, wrap.
        for (int i = 0; i < N_ROWS; i++)
        begin
            row = GESTURE_ROWS[i];
            send_sample(row.thr, row.yaw, row.now, row.typed, '{row.st, row.rs});
        end

        // Random part: sweep the delay through its extremes and the idling mixes;
        // the last phase stalls the result side long enough to back up the input.
        run_phase(16'd0, 0, 0, 0);
        run_phase(16'hFFFF, 62, 0, 0);
        run_phase(16'd1, 0, 62, 0);
        run_phase(DLY_W'($urandom_range(3000)), 23, 23, 0);
        run_phase(DLY_W'($urandom_range(65535)), 0, 0, PRESSURE_CYCLES);

        drain_requests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

>>> sim.f
hdl/sad_pkg.sv
hdl/sad_if.sv
hdl/sad_in_reg.sv
hdl/sad_core.sv
hdl/stick_arm_disarm_fsm.sv
tb/testbench.sv
